FILE: rtl/osae_pkg.sv
// Package for the ordered slot array engine.
// Holds the transfer payload types, operation and status codes, and the cell control struct.
// No dependencies.
package osae_pkg;

    // Operation codes.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    // Width used by cells to compare positions, counts and indexes (covers a count of 256).
    localparam int POS_W = 9;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] item_value;
        logic [3:0]         slot_index;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] found_index;
        logic [4:0] entry_count;
    } out_t;

    // Broadcast command to every cell; at most one bit is set in a cycle.
    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
        logic srch;
    } cell_ctl_t;

endpackage

FILE: rtl/ordered_slot_array_engine_unit.sv
// Ordered slot array engine: insert, delete, search and update on a chain of entry cells.
// Insert, delete and update: the result is registered in a result register, then moves to
// the output register once that has room; only then is a new item taken. Search: the same,
// after the cells register their match flags and the scan walks from index 0 to the first
// matching index (the count on a miss), one cell per cycle. A stalled output keeps one
// more result inside and then holds the input off. Reset (rst_n, async, low) empties it.
module ordered_slot_array_engine_unit #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  osae_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output osae_pkg::out_t out_data
);

    // Count must reach CAPACITY itself; an index addresses one of CAPACITY cells.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    // Control states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    osae_pkg::out_t          res_reg, res_next;
    osae_pkg::out_t          out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    accept;
    logic                    full;
    logic [CMP_W-1:0]        idx_w;
    logic [CMP_W-1:0]        cnt_w;
    logic [1:0]              dec_status;
    logic [CNT_W-1:0]        dec_cnt;
    osae_pkg::cell_ctl_t     ctl;
    logic                    scan_miss;
    logic                    scan_hit;
    logic                    out_free;

    logic signed [31:0]      cell_entry [CAPACITY];
    logic [CAPACITY-1:0]     match_vec;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Decode the incoming operation against the current count. The cells only see a
    // command when the operation is allowed, so a refused one changes nothing.
    assign full  = (cnt_reg == CNT_W'(CAPACITY));
    assign idx_w = CMP_W'(in_data.slot_index);
    assign cnt_w = CMP_W'(cnt_reg);

    always_comb
    begin
        dec_status = osae_pkg::ST_DONE;
        dec_cnt    = cnt_reg;
        ctl        = '0;
        case (in_data.op)
            osae_pkg::OP_INSERT:
            begin
                if (full)
                    dec_status = osae_pkg::ST_FULL;
                else if (idx_w > cnt_w)
                    dec_status = osae_pkg::ST_RANGE;
                else
                begin
                    ctl.ins = accept;
                    dec_cnt = cnt_reg + 1'b1;
                end
            end
            osae_pkg::OP_DELETE:
            begin
                if (idx_w >= cnt_w)
                    dec_status = osae_pkg::ST_RANGE;
                else
                begin
                    ctl.del = accept;
                    dec_cnt = cnt_reg - 1'b1;
                end
            end
            osae_pkg::OP_SEARCH:
            begin
                ctl.srch = accept;
            end
            osae_pkg::OP_UPDATE:
            begin
                if (idx_w >= cnt_w)
                    dec_status = osae_pkg::ST_RANGE;
                else
                    ctl.upd = accept;
            end
            default:
            begin
                dec_status = osae_pkg::ST_RANGE;
            end
        endcase
    end

    // The cell chain. Cell 0 has no left neighbor and the last cell no right neighbor;
    // their open sides only ever feed positions that are not in use.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [31:0] left_in;
        logic signed [31:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = in_data.item_value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_entry[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_in = cell_entry[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_entry[g+1];
        end

        osae_cell #(
            .CELL_POS (g),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .slot_index  (in_data.slot_index),
            .cnt         (cnt_reg),
            .item_value  (in_data.item_value),
            .left_entry  (left_in),
            .right_entry (right_in),
            .entry       (cell_entry[g]),
            .match       (match_vec[g])
        );
    end

    // Search scan: the cells registered their match flags on the transfer cycle; the
    // pointer then walks them from index 0 and stops at the first hit or at the count.
    assign scan_miss = (ptr_reg == cnt_reg);
    assign scan_hit  = match_vec[ptr_reg[IDX_W-1:0]];

    // The output register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.op == osae_pkg::OP_SEARCH)
                    begin
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cnt_next             = dec_cnt;
                        res_next.status      = dec_status;
                        res_next.found_index = '0;
                        res_next.entry_count = 5'(dec_cnt);
                        state_next           = S_HOLD;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_miss)
                begin
                    res_next.status      = osae_pkg::ST_MISS;
                    res_next.found_index = '0;
                    res_next.entry_count = 5'(cnt_reg);
                    state_next           = S_HOLD;
                end
                else if (scan_hit)
                begin
                    res_next.status      = osae_pkg::ST_DONE;
                    res_next.found_index = 4'(ptr_reg);
                    res_next.entry_count = 5'(cnt_reg);
                    state_next           = S_HOLD;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_HOLD:
            begin
                // Hand the finished result to the output register once it has room.
                if (out_free)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/osae_cell.sv
// One storage cell of the slot array chain.
// Holds one entry, shifts it to or from its neighbors, and flags a search match.
// Depends on osae_pkg.
module osae_cell #(
    parameter int CELL_POS = 0,
    parameter int CNT_W    = 5
) (
    input  logic                    clk,
    input  osae_pkg::cell_ctl_t     ctl,
    input  logic [3:0]              slot_index,
    input  logic [CNT_W-1:0]        cnt,
    input  logic signed [31:0]      item_value,
    input  logic signed [31:0]      left_entry,
    input  logic signed [31:0]      right_entry,
    output logic signed [31:0]      entry,
    output logic                    match
);

    localparam logic [osae_pkg::POS_W-1:0] POS = osae_pkg::POS_W'(CELL_POS);

    logic signed [31:0]            entry_reg;
    logic signed [31:0]            entry_next;
    logic                          match_reg;
    logic                          match_next;
    logic [osae_pkg::POS_W-1:0]    idx_w;
    logic [osae_pkg::POS_W-1:0]    cnt_w;

    assign idx_w = osae_pkg::POS_W'(slot_index);
    assign cnt_w = osae_pkg::POS_W'(cnt);

    always_comb
    begin
        entry_next = entry_reg;
        match_next = match_reg;
        if (ctl.ins)
        begin
            // The new value lands here; every later cell takes its left neighbor.
            if (POS == idx_w)
                entry_next = item_value;
            else if (POS > idx_w)
                entry_next = left_entry;
        end
        else if (ctl.del)
        begin
            if (POS >= idx_w)
                entry_next = right_entry;
        end
        else if (ctl.upd)
        begin
            if (POS == idx_w)
                entry_next = item_value;
        end
        else if (ctl.srch)
        begin
            match_next = (entry_reg == item_value) && (POS < cnt_w);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: rtl/osae_checker.sv
// Port-level checker for the ordered slot array engine, with its bind to the top level.
// Depends on osae_pkg and ordered_slot_array_engine_unit.
module osae_checker #(
    parameter int CAPACITY = 16
) (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input osae_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_ready,
    input osae_pkg::out_t out_data
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // Only a successful search reports a nonzero index.
    a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != osae_pkg::ST_DONE) |-> out_data.found_index == 4'd0)
        else $error("found_index set on a result that is not a hit");

    // A full refusal reports a full array.
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == osae_pkg::ST_FULL)
        |-> out_data.entry_count == 5'(CAPACITY))
        else $error("full status with a count below capacity");

    // The count never exceeds capacity when it fits the field.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAPACITY > 31) || (32'(out_data.entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    // An input item that waits for the engine stays offered with the same payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input item changed or withdrawn while waiting");

endmodule

bind ordered_slot_array_engine_unit osae_checker #(
    .CAPACITY (CAPACITY)
) u_osae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
